@@ design/sgtr_pkg.sv @@
package sgtr_pkg;

  // Frame geometry
  localparam int FRAME_WIDTH   = 320;
  localparam int FRAME_HEIGHT  = 240;
  localparam int MAX_SCALE     = 16;

  // Frame store: one word holds WORD_BITS horizontally adjacent pixels
  localparam int WORD_BITS     = 32;
  localparam int WORD_SHIFT    = $clog2(WORD_BITS);
  localparam int WORDS_PER_ROW = (FRAME_WIDTH + WORD_BITS - 1) / WORD_BITS;
  localparam int FRAME_WORDS   = WORDS_PER_ROW * FRAME_HEIGHT;
  localparam int ADDR_W        = $clog2(FRAME_WORDS);
  localparam int X_W           = $clog2(FRAME_WIDTH);
  localparam int Y_W           = $clog2(FRAME_HEIGHT);

  // Field and register widths
  localparam int ACTION_W      = 2;
  localparam int BITS_W        = 8;
  localparam int ROW_W         = 4;
  localparam int GW_W          = 4;
  localparam int RX_W          = 9;
  localparam int RY_W          = 8;
  localparam int PEN_W         = 12;
  localparam int SCALE_W       = 5;
  localparam int POS_W         = 10;
  localparam int FH_W          = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 10;

  // Internal datapath widths
  localparam int CNT_W         = $clog2(MAX_SCALE);
  localparam int XB_W          = PEN_W + 1;
  localparam int YB_W          = 12;
  localparam int ROW_OFF_W     = ROW_W + SCALE_W;

  // Constants of the rendering rule
  localparam int GLYPH_COLS    = 8;
  localparam int Y_OFFSET      = 9;
  localparam int PEN_MAX       = 2047;
  localparam int PEN_MIN       = -2048;

  // Reset values of the configuration registers
  localparam int SCALE_RST     = 1;
  localparam int FH_RST        = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_START = 2'd0,
    ACT_GLYPH = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE       = 2'd0,
    REG_ORIGIN_X    = 2'd1,
    REG_ORIGIN_Y    = 2'd2,
    REG_FONT_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_COL,
    ST_PIX,
    ST_READ,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic col_next;
    logic pix_step;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    action_t act;
    logic    clr_last;
    logic    col_end;
    logic    col_draw;
    logic    pix_last;
    logic    out_free;
  } dp_status_t;

  // Word address of a pixel inside the frame store
  function automatic logic [ADDR_W-1:0] word_addr(logic [X_W-1:0] x, logic [Y_W-1:0] y);
    return ADDR_W'(y) * ADDR_W'(WORDS_PER_ROW) + ADDR_W'(x >> WORD_SHIFT);
  endfunction

endpackage

@@ design/sgtr_if.sv @@
// Item channel into the renderer
interface sgtr_in_if import sgtr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BITS_W-1:0]   row_bits;
  logic [ROW_W-1:0]    row_index;
  logic [GW_W-1:0]     glyph_width;
  logic                last_row;
  logic [RX_W-1:0]     read_x;
  logic [RY_W-1:0]     read_y;

  modport source (
    output valid, action, row_bits, row_index, glyph_width, last_row, read_x, read_y,
    input  ready
  );
  modport sink (
    input  valid, action, row_bits, row_index, glyph_width, last_row, read_x, read_y,
    output ready
  );
endinterface

// Result channel out of the renderer
interface sgtr_out_if import sgtr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    pixel;
  logic signed [PEN_W-1:0] pen_x;

  modport source (output valid, pixel, pen_x, input ready);
  modport sink   (input  valid, pixel, pen_x, output ready);
endinterface

@@ design/sgtr_ctrl.sv @@
module sgtr_ctrl import sgtr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (action_t'(sts.act))
            default: state_next = ST_FINISH;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_COL: begin
        if (sts.col_end) begin
          state_next = ST_FINISH;
        end else if (sts.col_draw) begin
          state_next = ST_PIX;
        end else begin
          cmd.col_next = 1'b1;
        end
      end
      ST_PIX: begin
        cmd.pix_step = 1'b1;
        if (sts.pix_last) begin
          cmd.col_next = 1'b1;
          state_next   = ST_COL;
        end
      end
      ST_READ: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
    // Branch on the incoming action once the item is taken
    if (state == ST_IDLE && in_valid) begin
      case (sts.act)
        ACT_START: state_next = ST_CLEAR;
        ACT_GLYPH: state_next = ST_COL;
        ACT_READ:  state_next = ST_READ;
        default:   state_next = ST_FINISH;
      endcase
    end
  end

endmodule

@@ design/sgtr_dp.sv @@
module sgtr_dp import sgtr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_idx,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // item payload
  input  logic [ACTION_W-1:0]     action,
  input  logic [BITS_W-1:0]       row_bits,
  input  logic [ROW_W-1:0]        row_index,
  input  logic [GW_W-1:0]         glyph_width,
  input  logic                    last_row,
  input  logic [RX_W-1:0]         read_x,
  input  logic [RY_W-1:0]         read_y,
  // result register
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_pixel,
  output logic signed [PEN_W-1:0] out_pen,
  // controller link
  input  ctrl_cmd_t               cmd,
  output dp_status_t              sts
);

  // Configuration registers
  logic [SCALE_W-1:0]        scale;
  logic signed [POS_W-1:0]   origin_x;
  logic signed [POS_W-1:0]   origin_y;
  logic [FH_W-1:0]           font_height;

  // Item state
  action_t                   act;
  logic [BITS_W-1:0]         bits_sh;
  logic [GW_W-1:0]           col;
  logic [GW_W-1:0]           width;
  logic                      last;
  logic                      row_ok;
  logic signed [YB_W-1:0]    yb;
  logic signed [XB_W-1:0]    xb;
  logic [CNT_W-1:0]          di;
  logic [CNT_W-1:0]          dj;
  logic [RX_W-1:0]           rd_x;
  logic [RY_W-1:0]           rd_y;
  logic                      rd_ok;
  logic signed [PEN_W-1:0]   pen;
  logic [ADDR_W-1:0]         clr_addr;

  // Frame store write request and read port
  logic                      wr_en;
  logic                      wr_clear;
  logic [ADDR_W-1:0]         wr_addr;
  logic [WORD_SHIFT-1:0]     wr_bit;
  logic [WORD_BITS-1:0]      mem [FRAME_WORDS];
  logic [WORD_BITS-1:0]      rd_data;
  logic [ADDR_W-1:0]         rd_addr;

  // Combinational helpers
  logic [SCALE_W-1:0]        s_eff;
  logic [GW_W-1:0]           width_clamp;
  logic [ROW_OFF_W-1:0]      row_off;
  logic signed [YB_W-1:0]    yb_calc;
  logic signed [XB_W-1:0]    px;
  logic signed [YB_W-1:0]    py;
  logic                      in_frame;
  logic signed [XB_W:0]      adv;
  logic signed [PEN_W-1:0]   pen_sat;
  logic signed [PEN_W-1:0]   pen_new;

  // Scale clamped to 1..MAX_SCALE
  always_comb begin
    if (scale == '0) begin
      s_eff = SCALE_W'(1);
    end else if (scale > SCALE_W'(MAX_SCALE)) begin
      s_eff = SCALE_W'(MAX_SCALE);
    end else begin
      s_eff = scale;
    end
  end

  assign width_clamp = (glyph_width > GW_W'(GLYPH_COLS)) ? GW_W'(GLYPH_COLS) : glyph_width;

  // Top row of the glyph row's blocks
  assign row_off = ROW_OFF_W'(row_index) * ROW_OFF_W'(s_eff);
  assign yb_calc = $signed({{(YB_W-POS_W){origin_y[POS_W-1]}}, origin_y})
                 + $signed(YB_W'(row_off))
                 + $signed(YB_W'(Y_OFFSET))
                 - $signed(YB_W'(font_height));

  // Current pixel and clipping
  assign px       = xb + $signed(XB_W'(di));
  assign py       = yb + $signed(YB_W'(dj));
  assign in_frame = !px[XB_W-1] && (px < $signed(XB_W'(FRAME_WIDTH)))
                 && !py[YB_W-1] && (py < $signed(YB_W'(FRAME_HEIGHT)));

  // Pen advance: column sweep has already added width*scale
  assign adv = $signed({xb[XB_W-1], xb}) + $signed((XB_W+1)'(s_eff));
  always_comb begin
    if (adv > $signed((XB_W+1)'(PEN_MAX))) begin
      pen_sat = PEN_W'(PEN_MAX);
    end else if (adv < $signed((XB_W+1)'(PEN_MIN))) begin
      pen_sat = PEN_W'(PEN_MIN);
    end else begin
      pen_sat = PEN_W'(adv);
    end
  end
  assign pen_new = (act == ACT_GLYPH && last) ? pen_sat : pen;

  // Status; the action is only looked at while an item is offered
  assign sts.act      = action_t'(action);
  assign sts.clr_last = (clr_addr == ADDR_W'(FRAME_WORDS - 1));
  assign sts.col_end  = (col == width);
  assign sts.col_draw = row_ok && bits_sh[BITS_W-1];
  assign sts.pix_last = (SCALE_W'(di) == s_eff - SCALE_W'(1))
                     && (SCALE_W'(dj) == s_eff - SCALE_W'(1));
  assign sts.out_free = !out_valid || out_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scale       <= SCALE_W'(SCALE_RST);
      origin_x    <= '0;
      origin_y    <= '0;
      font_height <= FH_W'(FH_RST);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_SCALE:       scale       <= cfg_data[SCALE_W-1:0];
        REG_ORIGIN_X:    origin_x    <= $signed(cfg_data[POS_W-1:0]);
        REG_ORIGIN_Y:    origin_y    <= $signed(cfg_data[POS_W-1:0]);
        REG_FONT_HEIGHT: font_height <= cfg_data[FH_W-1:0];
        default:         scale       <= scale;
      endcase
    end
  end

  // Control state: pen, clear counter, write strobe, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pen       <= '0;
      clr_addr  <= '0;
      wr_en     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      wr_en <= cmd.clr_step || (cmd.pix_step && in_frame);
      if (cmd.load) begin
        clr_addr <= '0;
        if (action_t'(action) == ACT_START) begin
          pen <= {{(PEN_W-POS_W){origin_x[POS_W-1]}}, origin_x};
        end
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cmd.finish) begin
        pen       <= pen_new;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item registers and sweep counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act     <= action_t'(action);
      bits_sh <= row_bits;
      col     <= '0;
      width   <= width_clamp;
      last    <= last_row;
      row_ok  <= (FH_W'(row_index) < font_height);
      yb      <= yb_calc;
      xb      <= {pen[PEN_W-1], pen};
      di      <= '0;
      dj      <= '0;
      rd_x    <= read_x;
      rd_y    <= read_y;
      rd_ok   <= (read_x < RX_W'(FRAME_WIDTH)) && (read_y < RY_W'(FRAME_HEIGHT));
    end
    // Next column restarts the block counters, else step through the block
    if (cmd.col_next) begin
      col     <= col + GW_W'(1);
      xb      <= xb + $signed(XB_W'(s_eff));
      bits_sh <= bits_sh << 1;
      di      <= '0;
      dj      <= '0;
    end else if (cmd.pix_step) begin
      if (SCALE_W'(dj) == s_eff - SCALE_W'(1)) begin
        dj <= '0;
        di <= di + CNT_W'(1);
      end else begin
        dj <= dj + CNT_W'(1);
      end
    end
    if (cmd.finish) begin
      out_pixel <= (act == ACT_READ) && rd_ok && rd_data[rd_x[WORD_SHIFT-1:0]];
      out_pen   <= pen_new;
    end
  end

  // Write request, registered from the sweep step
  always_ff @(posedge clk) begin
    wr_clear <= cmd.clr_step;
    wr_addr  <= cmd.clr_step ? clr_addr : word_addr(X_W'(px), Y_W'(py));
    wr_bit   <= px[WORD_SHIFT-1:0];
  end

  assign rd_addr = word_addr(X_W'(rd_x), Y_W'(rd_y));

  // Frame store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_clear) begin
        mem[wr_addr] <= '0;
      end else begin
        mem[wr_addr][wr_bit] <= 1'b1;
      end
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/scaled_glyph_text_raster_top.sv @@
// Scaled glyph text raster.
// Items arrive on the items channel (valid/ready); one result per item leaves
// on the results channel (valid/ready). An item is taken when valid and ready
// are both high at a rising edge. Configuration is a plain write port
// (cfg_we, cfg_idx, cfg_data): 0 scale, 1 origin_x, 2 origin_y, 3 font_height.
// The frame store holds 32 pixels per word, 2400 words; the single write port
// sets one pixel per cycle or clears one word per cycle.
// Work per item, from acceptance to result: a start clears the store one word
// per cycle; a glyph row steps through its columns and, for each set bit of a
// drawn row, writes a block of scale by scale pixels; a read pixel makes a
// registered memory read; an unused action goes straight to its result.
// A start is the longest item.
// Reset: synchronous on rst; after it the store is cleared word by word,
// during which ready stays low; configuration writes are taken throughout.
// A finished result sits in an output register; the next item may be taken
// while it waits, but its own result is held back until the receiver takes
// the earlier one.
module scaled_glyph_text_raster_top import sgtr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sgtr_in_if.sink               items,
  sgtr_out_if.source            results
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  sgtr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sgtr_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .action      (items.action),
    .row_bits    (items.row_bits),
    .row_index   (items.row_index),
    .glyph_width (items.glyph_width),
    .last_row    (items.last_row),
    .read_x      (items.read_x),
    .read_y      (items.read_y),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_pixel   (results.pixel),
    .out_pen     (results.pen_x),
    .cmd         (cmd),
    .sts         (sts)
  );

  // A result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_free)
    else $error("result loaded over an untaken result");

  // Loading, clearing and drawing never share a cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.clr_step, cmd.pix_step, cmd.finish}))
    else $error("conflicting datapath commands");

  // The clearing pass stops at the last word of the store
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.clr_step && sts.clr_last) |=> !cmd.clr_step)
    else $error("clearing pass ran past the end of the store");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import sgtr_pkg::*;

  // One item as offered on the items channel
  typedef struct packed {
    action_t           act;
    logic [BITS_W-1:0] row_bits;
    logic [ROW_W-1:0]  row_index;
    logic [GW_W-1:0]   glyph_width;
    logic              last_row;
    logic [RX_W-1:0]   read_x;
    logic [RY_W-1:0]   read_y;
  } glyph_item_t;

  // One result as seen on the results channel
  typedef struct packed {
    logic                    pixel;
    logic signed [PEN_W-1:0] pen_x;
  } pen_pixel_t;

  localparam int MAX_REPORTS = 200;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sgtr_in_if  items_if ();
  sgtr_out_if results_if ();

  scaled_glyph_text_raster_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .items    (items_if),
    .results  (results_if)
  );

  // Shadow of the block: registers, frame store and pen
  int                      scale_cfg    = SCALE_RST;
  int                      origin_x_cfg = 0;
  int                      origin_y_cfg = 0;
  int                      font_h_cfg   = FH_RST;
  logic [FRAME_WIDTH-1:0]  shadow_frame [FRAME_HEIGHT];
  int                      shadow_pen   = 0;

  glyph_item_t item_q [$];
  pen_pixel_t  pen_pixel_q [$];
  glyph_item_t cur_item;

  int send_gap     = 0;
  int recv_gap     = 0;
  int hold_cycles  = 0;
  int n_results    = 0;
  int next_squeeze = 10;
  int fail_cnt     = 0;
  bit calm         = 1'b0;

  // Stimulus generator's own idea of the pen, used to aim reads at the text
  int gen_pen   = 0;
  int gen_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int eff_scale(int s);
    if (s == 0) return 1;
    if (s > MAX_SCALE) return MAX_SCALE;
    return s;
  endfunction

  // Gap length for either side: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Apply one item to the shadow state and return the result it should give
  function automatic pen_pixel_t render_item(glyph_item_t it);
    pen_pixel_t res;
    int         s, w, y0, x0, px, py, r, c, i, j;
    res.pixel = 1'b0;
    case (it.act)
      ACT_START: begin
        for (r = 0; r < FRAME_HEIGHT; r++) shadow_frame[r] = '0;
        shadow_pen = origin_x_cfg;
      end
      ACT_GLYPH: begin
        s = eff_scale(scale_cfg);
        w = (it.glyph_width > GLYPH_COLS) ? GLYPH_COLS : int'(it.glyph_width);
        // rows past the font height draw nothing but may still move the pen
        if (int'(it.row_index) < font_h_cfg) begin
          y0 = origin_y_cfg + int'(it.row_index) * s + Y_OFFSET - font_h_cfg;
          for (c = 0; c < w; c++) begin
            if (it.row_bits[GLYPH_COLS-1-c]) begin
              x0 = shadow_pen + c * s;
              for (i = 0; i < s; i++) begin
                for (j = 0; j < s; j++) begin
                  px = x0 + i;
                  py = y0 + j;
                  if (px >= 0 && px < FRAME_WIDTH && py >= 0 && py < FRAME_HEIGHT)
                    shadow_frame[py][px] = 1'b1;
                end
              end
            end
          end
        end
        if (it.last_row) begin
          shadow_pen = shadow_pen + w * s + s;
          if (shadow_pen > PEN_MAX) shadow_pen = PEN_MAX;
          if (shadow_pen < PEN_MIN) shadow_pen = PEN_MIN;
        end
      end
      ACT_READ: begin
        if (it.read_x < FRAME_WIDTH && it.read_y < FRAME_HEIGHT)
          res.pixel = shadow_frame[it.read_y][it.read_x];
      end
      default: ;
    endcase
    res.pen_x = PEN_W'(shadow_pen);
    return res;
  endfunction

  // Driver: offers queued items, with random idle gaps between transactions
  always @(posedge clk) begin
    if (rst) begin
      items_if.valid <= 1'b0;
    end else begin
      if (items_if.valid && items_if.ready)
        pen_pixel_q.push_back(render_item(cur_item));
      if (!items_if.valid || items_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          items_if.valid <= 1'b0;
        end else if (item_q.size() == 0) begin
          items_if.valid <= 1'b0;
        end else begin
          cur_item = item_q.pop_front();
          items_if.action      <= cur_item.act;
          items_if.row_bits    <= cur_item.row_bits;
          items_if.row_index   <= cur_item.row_index;
          items_if.glyph_width <= cur_item.glyph_width;
          items_if.last_row    <= cur_item.last_row;
          items_if.read_x      <= cur_item.read_x;
          items_if.read_y      <= cur_item.read_y;
          items_if.valid       <= 1'b1;
          send_gap = pick_gap();
        end
      end
    end
  end

  // Monitor: checks each result transaction and throttles ready
  always @(posedge clk) begin
    pen_pixel_t want;
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        n_results++;
        if (pen_pixel_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual pixel %0b pen_x %0d",
                     $time, results_if.pixel, results_if.pen_x);
        end else begin
          want = pen_pixel_q.pop_front();
          if (results_if.pixel !== want.pixel) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display("%0t: pixel mismatch, expected %0b, actual %0b",
                       $time, want.pixel, results_if.pixel);
          end
          if (results_if.pen_x !== want.pen_x) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display("%0t: pen_x mismatch, expected %0d, actual %0d",
                       $time, want.pen_x, results_if.pen_x);
          end
        end
        // long hold-off while items are still queued, so the input backs up
        if (n_results >= next_squeeze && item_q.size() >= 8) begin
          hold_cycles = 2500;
          next_squeeze = n_results + 600;
        end else if (!calm && $urandom_range(0, 299) == 0) begin
          hold_cycles = $urandom_range(100, 400);
        end else begin
          recv_gap = pick_gap();
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        results_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      REG_SCALE:       scale_cfg    = int'(data[SCALE_W-1:0]);
      REG_ORIGIN_X:    origin_x_cfg = int'($signed(data[POS_W-1:0]));
      REG_ORIGIN_Y:    origin_y_cfg = int'($signed(data[POS_W-1:0]));
      REG_FONT_HEIGHT: font_h_cfg   = int'(data[FH_W-1:0]);
      default: ;
    endcase
  endtask

  // Writes all four registers; spare data bits above scale and height are junk now and then
  task automatic apply_settings(int sc, int ox, int oy, int fh);
    logic [CFG_DATA_W-1:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : '0;
    write_reg(REG_SCALE, {junk[CFG_DATA_W-1:SCALE_W], SCALE_W'(sc)});
    write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
    write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
    write_reg(REG_FONT_HEIGHT, {junk[CFG_DATA_W-1:FH_W], FH_W'(fh)});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender pause: wait until every queued item has gone and every result has come
  task automatic drain();
    do @(negedge clk);
    while (item_q.size() != 0 || pen_pixel_q.size() != 0 || items_if.valid);
  endtask

  task automatic push_item(action_t a, int bits, int row, int gw, int last, int rx, int ry);
    glyph_item_t it;
    it.act         = a;
    it.row_bits    = BITS_W'(bits);
    it.row_index   = ROW_W'(row);
    it.glyph_width = GW_W'(gw);
    it.last_row    = 1'(last);
    it.read_x      = RX_W'(rx);
    it.read_y      = RY_W'(ry);
    item_q.push_back(it);
    if (a != ACT_NONE) gen_count++;
  endtask

  task automatic gen_advance(int gw, int last);
    int s;
    s = eff_scale(scale_cfg);
    if (last[0]) begin
      gen_pen = gen_pen + ((gw > GLYPH_COLS) ? GLYPH_COLS : gw) * s + s;
      if (gen_pen > PEN_MAX) gen_pen = PEN_MAX;
    end
  endtask

  // Read aimed at the glyph being drawn, else anywhere the fields reach
  task automatic push_read_near();
    int s, x, y;
    s = eff_scale(scale_cfg);
    x = gen_pen + int'($urandom_range(0, 9 * s));
    y = origin_y_cfg + Y_OFFSET - font_h_cfg + int'($urandom_range(0, 16 * s));
    if (x < 0 || x > 511 || y < 0 || y > 255) begin
      x = $urandom_range(0, 511);
      y = $urandom_range(0, 255);
    end
    push_item(ACT_READ, $urandom, $urandom, $urandom, $urandom, x, y);
  endtask

  // Random junk: unused action, stray start, or any glyph row or read
  task automatic push_noise();
    int r, gw, last;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      push_item(ACT_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (r < 36) begin
      push_item(ACT_START, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      gen_pen = origin_x_cfg;
    end else if (r < 70) begin
      gw = $urandom_range(0, 15);
      last = $urandom_range(0, 1);
      push_item(ACT_GLYPH, $urandom, $urandom, gw, last, $urandom, $urandom);
      gen_advance(gw, last);
    end else begin
      push_item(ACT_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic push_glyph();
    int r, gw, nrows, row, bits;
    r = $urandom_range(0, 99);
    if (r < 5) gw = 0;
    else if (r < 15) gw = $urandom_range(9, 15);
    else gw = $urandom_range(1, GLYPH_COLS);
    if (font_h_cfg >= 1 && font_h_cfg <= 16) begin
      nrows = font_h_cfg;
      // now and then run past the font height
      if (font_h_cfg < 16 && $urandom_range(0, 9) == 0)
        nrows = $urandom_range(font_h_cfg + 1, 16);
    end else begin
      nrows = $urandom_range(1, 16);
    end
    for (row = 0; row < nrows; row++) begin
      r = $urandom_range(0, 99);
      if (r < 20) bits = 8'hFF;
      else if (r < 30) bits = 0;
      else bits = $urandom_range(0, 255);
      push_item(ACT_GLYPH, bits, row, gw, (row == nrows - 1), $urandom, $urandom);
      if ($urandom_range(0, 4) == 0) push_read_near();
      if ($urandom_range(0, 29) == 0) push_noise();
    end
    gen_advance(gw, 1);
  endtask

  task automatic push_string(int nglyphs);
    int g;
    push_item(ACT_START, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    gen_pen = origin_x_cfg;
    for (g = 0; g < nglyphs; g++) push_glyph();
    repeat ($urandom_range(3, 6)) push_read_near();
    push_item(ACT_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic run_phase(int sc, int ox, int oy, int fh, int nstrings, int gmax);
    apply_settings(sc, ox, oy, fh);
    calm = ($urandom_range(0, 3) == 0);
    repeat (nstrings) push_string($urandom_range(1, gmax));
    drain();
  endtask

  // Timeout
  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int r, sc, ox, oy, fh, s, gmax, k;
    items_if.valid       = 1'b0;
    items_if.action      = '0;
    items_if.row_bits    = '0;
    items_if.row_index   = '0;
    items_if.glyph_width = '0;
    items_if.last_row    = 1'b0;
    items_if.read_x      = '0;
    items_if.read_y      = '0;
    results_if.ready     = 1'b0;
    for (k = 0; k < FRAME_HEIGHT; k++) shadow_frame[k] = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, read before any start, unused action,
    // wide glyph, rows past the font height, zero width, reads outside
    push_item(ACT_READ, 0, 0, 0, 0, 5, 5);
    push_item(ACT_NONE, 8'hFF, 15, 15, 1, 511, 255);
    push_item(ACT_START, 0, 0, 0, 0, 0, 0);
    push_item(ACT_GLYPH, 8'hFF, 0, 8, 0, 0, 0);
    push_item(ACT_GLYPH, 8'h80, 7, 15, 1, 0, 0);
    push_item(ACT_GLYPH, 8'hFF, 8, 8, 1, 0, 0);
    push_item(ACT_GLYPH, 8'h01, 3, 0, 1, 0, 0);
    push_item(ACT_GLYPH, 8'h55, 15, 8, 0, 0, 0);
    push_item(ACT_READ, 0, 0, 0, 0, 0, 1);
    push_item(ACT_READ, 0, 0, 0, 0, 7, 1);
    push_item(ACT_READ, 0, 0, 0, 0, 8, 1);
    push_item(ACT_READ, 0, 0, 0, 0, 0, 8);
    push_item(ACT_READ, 0, 0, 0, 0, 1, 8);
    push_item(ACT_READ, 0, 0, 0, 0, 319, 239);
    push_item(ACT_READ, 0, 0, 0, 0, 320, 0);
    push_item(ACT_READ, 0, 0, 0, 0, 0, 240);
    push_item(ACT_READ, 8'hFF, 15, 15, 1, 511, 255);
    drain();

    // Extreme settings: scale zero and above the maximum, origins at both
    // ends, font height zero, one, sixteen and beyond
    run_phase(0, -512, -512, 0, 1, 3);
    run_phase(31, 511, 511, 31, 1, 1);
    run_phase(16, -10, 30, 8, 1, 2);
    run_phase(1, 300, 225, 1, 2, 6);
    run_phase(1, 0, 0, 16, 1, 4);
    run_phase(2, 5, 100, 31, 1, 3);

    // Pen saturation: big scale, cheap rows past a one-row font
    apply_settings(16, 480, 0, 1);
    push_item(ACT_START, 0, 0, 0, 0, 0, 0);
    for (k = 0; k < 15; k++) begin
      push_item(ACT_GLYPH, $urandom, $urandom_range(1, 15), 8, 1, $urandom, $urandom);
      push_item(ACT_READ, 0, 0, 0, 0, $urandom_range(0, 511), $urandom_range(0, 255));
    end
    push_item(ACT_GLYPH, 8'hFF, 0, 8, 1, 0, 0);
    drain();

    // Random phases, mostly small scales
    gen_count = 0;
    while (gen_count < 1500) begin
      r = $urandom_range(0, 99);
      if (r < 70) sc = $urandom_range(1, 4);
      else if (r < 90) sc = $urandom_range(5, 8);
      else if (r < 97) sc = $urandom_range(9, 12);
      else sc = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
      ox = ($urandom_range(0, 99) < 85) ? int'($urandom_range(0, 330)) - 30
                                        : int'($urandom_range(0, 1023)) - 512;
      oy = ($urandom_range(0, 99) < 85) ? int'($urandom_range(0, 250)) - 20
                                        : int'($urandom_range(0, 1023)) - 512;
      r = $urandom_range(0, 99);
      if (r < 80) fh = $urandom_range(5, 16);
      else if (r < 95) fh = $urandom_range(1, 4);
      else fh = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
      s = eff_scale(sc);
      gmax = (s <= 4) ? 6 : (s <= 8) ? 3 : 1;
      run_phase(sc, ox, oy, fh, $urandom_range(1, 3), gmax);
    end

    // Let any stray result show up before the verdict
    repeat (2500) @(posedge clk);
    if (fail_cnt == 0 && pen_pixel_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
